>>> sv/assert_macros.svh
// Assertion macros used by the checker in snd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, skipped while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: label");

// Clocked check that also runs through reset.
`define ASSERT_CLK_ALL(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed: label");

`endif

>>> sv/snd_pkg.sv
// Types, constants and the tag table for the subscribe notice deframer.
`timescale 1ns / 1ps

package snd_pkg;

   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam int LIMIT_W             = 16;
   localparam int MSG_LEN_W           = 16;
   localparam int TAG_POS_W           = 4;

   localparam logic [TAG_POS_W-1:0] TAG_LEN   = 4'd13;
   localparam logic [TAG_POS_W-1:0] TAG_LAST  = 4'd12;
   localparam logic [LIMIT_W-1:0]   LIMIT_RESET = 16'd2047;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_LINK,
      PH_QUOTE,
      PH_TOPIC,
      PH_COMMA,
      PH_LENGTH,
      PH_PAYLOAD
   } phase_type;

   typedef struct packed {
      logic [7:0]           payload_byte;
      logic                 byte_kept;
      logic                 last_of_message;
      logic [MSG_LEN_W-1:0] message_length;
   } rsp_type;

   // "+MQTTSUBRECV:"
   function automatic logic [7:0] tag_char(input logic [TAG_POS_W-1:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = CH_PLUS;
         4'd1:    c = 8'h4D;
         4'd2:    c = 8'h51;
         4'd3:    c = 8'h54;
         4'd4:    c = 8'h54;
         4'd5:    c = 8'h53;
         4'd6:    c = 8'h55;
         4'd7:    c = 8'h42;
         4'd8:    c = 8'h52;
         4'd9:    c = 8'h45;
         4'd10:   c = 8'h43;
         4'd11:   c = 8'h56;
         4'd12:   c = 8'h3A;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

>>> sv/snd_parser.sv
// Header parser and payload counter: each taken request updates the state registers.
`timescale 1ns / 1ps

module snd_parser
   import snd_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  logic [7:0]         rx_byte,
   input  logic [LIMIT_W-1:0] payload_limit,
   output logic               res_valid,
   output rsp_type            res
);

   localparam int ACC_W = LENGTH_BITS + 4;
   localparam int CMP_W = (LENGTH_BITS > LIMIT_W) ? LENGTH_BITS : LIMIT_W;
   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

   phase_type              phase_ff, phase_in;
   logic [TAG_POS_W-1:0]   tag_pos_ff, tag_pos_in;
   logic [LENGTH_BITS-1:0] len_acc_ff, len_acc_in;
   logic [LENGTH_BITS-1:0] pay_cnt_ff, pay_cnt_in;

   logic                   is_digit;
   logic [3:0]             digit;
   logic [ACC_W-1:0]       len_mac;
   logic [LENGTH_BITS-1:0] len_sat;
   logic [LENGTH_BITS-1:0] cnt_inc;
   logic                   tag_hit;
   logic [TAG_POS_W-1:0]   restart_pos;
   logic [CMP_W-1:0]       cnt_ext;
   logic [CMP_W-1:0]       limit_ext;
   logic [CMP_W-1:0]       acc_ext;

   assign is_digit    = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
   assign digit       = 4'(rx_byte - CH_ZERO);
   assign len_mac     = (ACC_W'(len_acc_ff) << 3) + (ACC_W'(len_acc_ff) << 1) + ACC_W'(digit);
   assign len_sat     = (len_mac > ACC_W'(LEN_MAX)) ? LEN_MAX : len_mac[LENGTH_BITS-1:0];
   assign cnt_inc     = pay_cnt_ff + 1'b1;
   assign tag_hit     = (tag_pos_ff < TAG_LEN) && (rx_byte == tag_char(tag_pos_ff));
   assign restart_pos = (rx_byte == CH_PLUS) ? TAG_POS_W'(1) : '0;
   assign cnt_ext     = CMP_W'(pay_cnt_ff);
   assign limit_ext   = CMP_W'(payload_limit);
   assign acc_ext     = CMP_W'(len_acc_ff);

   // next state
   always_comb begin
      phase_in   = phase_ff;
      tag_pos_in = tag_pos_ff;
      len_acc_in = len_acc_ff;
      pay_cnt_in = pay_cnt_ff;
      unique case (phase_ff)
         PH_HUNT: begin
            if (tag_hit) begin
               if (tag_pos_ff == TAG_LAST) begin
                  tag_pos_in = '0;
                  phase_in   = PH_LINK;
               end else begin
                  tag_pos_in = tag_pos_ff + 1'b1;
               end
            end else begin
               tag_pos_in = restart_pos;
            end
         end
         PH_LINK: begin
            if (rx_byte == CH_COMMA) phase_in = PH_QUOTE;
         end
         PH_QUOTE: begin
            if (rx_byte == CH_QUOTE) begin
               phase_in = PH_TOPIC;
            end else begin
               phase_in   = PH_HUNT;
               tag_pos_in = restart_pos;
            end
         end
         PH_TOPIC: begin
            if (rx_byte == CH_QUOTE) phase_in = PH_COMMA;
         end
         PH_COMMA: begin
            if (rx_byte == CH_COMMA) begin
               phase_in   = PH_LENGTH;
               len_acc_in = '0;
            end else begin
               phase_in   = PH_HUNT;
               tag_pos_in = restart_pos;
            end
         end
         PH_LENGTH: begin
            if (is_digit) begin
               len_acc_in = len_sat;
            end else if (rx_byte == CH_COMMA && len_acc_ff != '0) begin
               phase_in   = PH_PAYLOAD;
               pay_cnt_in = '0;
            end else begin
               phase_in   = PH_HUNT;
               tag_pos_in = restart_pos;
            end
         end
         PH_PAYLOAD: begin
            pay_cnt_in = cnt_inc;
            if (cnt_inc == len_acc_ff) begin
               phase_in   = PH_HUNT;
               tag_pos_in = '0;
            end
         end
         default: begin
            phase_in   = PH_HUNT;
            tag_pos_in = restart_pos;
         end
      endcase
   end

   // outputs
   always_comb begin
      res_valid           = 1'b0;
      res.payload_byte    = rx_byte;
      res.byte_kept       = cnt_ext < limit_ext;
      res.last_of_message = cnt_inc == len_acc_ff;
      res.message_length  = acc_ext[MSG_LEN_W-1:0];
      unique case (phase_ff)
         PH_PAYLOAD: res_valid = req_fire;
         default:    res_valid = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         tag_pos_ff <= '0;
         len_acc_ff <= '0;
         pay_cnt_ff <= '0;
      end else if (req_fire) begin
         phase_ff   <= phase_in;
         tag_pos_ff <= tag_pos_in;
         len_acc_ff <= len_acc_in;
         pay_cnt_ff <= pay_cnt_in;
      end
   end

endmodule

>>> sv/snd_out_buffer.sv
// Result register with one skid entry, so requests keep flowing under a stall.
`timescale 1ns / 1ps

module snd_out_buffer
   import snd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_data,
   output logic    full,
   output logic    out_valid,
   output rsp_type out_data,
   input  logic    out_stall
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    out_free;

   assign out_free = !out_valid_ff || !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         out_valid_in  = skid_valid_ff || in_valid;
         out_in        = skid_valid_ff ? skid_ff : in_data;
         skid_valid_in = 1'b0;
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

>>> sv/subscribe_notice_deframer.sv
// Top level of the subscribe notice deframer.
//
//   port group  direction  handshake            contents
//   req_        in         valid / stall        one received byte
//   rsp_        out        valid / stall        payload byte, kept, last, length
//   csr_        in         valid / ready        payload_limit
//
// One request per cycle unless req_stall is high; rsp_ outputs are registered.
// Header bytes produce no response. The result register plus one skid entry
// let requests continue while rsp_ stalls; req_stall rises once both hold data.
// Synchronous reset returns to tag hunting and sets payload_limit to 2047.
// csr_ready is always high; write only while no request is in flight.
`timescale 1ns / 1ps

module subscribe_notice_deframer
   import snd_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_payload_byte,
   output logic                 rsp_byte_kept,
   output logic                 rsp_last_of_message,
   output logic [MSG_LEN_W-1:0] rsp_message_length,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [LIMIT_W-1:0]   csr_payload_limit
);

   logic [LIMIT_W-1:0] payload_limit_ff;
   logic               req_fire;
   logic               res_valid;
   rsp_type            res;
   rsp_type            rsp;
   logic               buf_full;

   assign csr_ready = 1'b1;
   assign req_stall = buf_full;
   assign req_fire  = req_valid && !buf_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         payload_limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         payload_limit_ff <= csr_payload_limit;
      end
   end

   snd_parser #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .req_fire     (req_fire),
      .rx_byte      (req_rx_byte),
      .payload_limit(payload_limit_ff),
      .res_valid    (res_valid),
      .res          (res)
   );

   snd_out_buffer u_out_buffer (
      .clock    (clock),
      .reset    (reset),
      .in_valid (res_valid),
      .in_data  (res),
      .full     (buf_full),
      .out_valid(rsp_valid),
      .out_data (rsp),
      .out_stall(rsp_stall)
   );

   assign rsp_payload_byte    = rsp.payload_byte;
   assign rsp_byte_kept       = rsp.byte_kept;
   assign rsp_last_of_message = rsp.last_of_message;
   assign rsp_message_length  = rsp.message_length;

endmodule

>>> sv/snd_checker.sv
// Port-level checks for the subscribe notice deframer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module snd_checker
   import snd_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [7:0]           rsp_payload_byte,
   input logic                 rsp_byte_kept,
   input logic                 rsp_last_of_message,
   input logic [MSG_LEN_W-1:0] rsp_message_length
);

   logic [MSG_LEN_W+9:0] rsp_bits;

   assign rsp_bits = {rsp_payload_byte, rsp_byte_kept, rsp_last_of_message, rsp_message_length};

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bits))
   `ASSERT_CLK(a_rsp_from_req, clock, reset, $rose(rsp_valid) |-> $past(req_valid && !req_stall))
   `ASSERT_CLK(a_stall_needs_rsp, clock, reset, req_stall |-> rsp_valid)
   `ASSERT_CLK_ALL(a_reset_clear, clock, $past(reset) |-> !rsp_valid && !req_stall)

endmodule

bind subscribe_notice_deframer snd_checker u_snd_checker (.*);
